// ----- hw/rtl/mmbga_pkg.sv -----
// Package for the matmul backward gradient accumulator.
// Holds sizes, opcodes, register indexes, the configuration layout and the dimension clamp.
// No dependencies.
`default_nettype none
package mmbga_pkg;
	localparam int MaxDim = 16;
	localparam int FracBits = 16;
	localparam int IdxW = $clog2(MaxDim);
	localparam int AddrW = 2 * IdxW;
	localparam int Cells = MaxDim * MaxDim;
	localparam int DimW = 5;
	localparam int AccW = 52;

	typedef enum logic [2:0] {
		OP_LOAD_A  = 3'd0,
		OP_LOAD_B  = 3'd1,
		OP_LOAD_G  = 3'd2,
		OP_COMPUTE = 3'd3,
		OP_READ_GA = 3'd4,
		OP_READ_GB = 3'd5,
		OP_CLEAR   = 3'd6,
		OP_NONE    = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		REG_SHAPE = 3'd0,
		REG_ROWS  = 3'd1,
		REG_INNER = 3'd2,
		REG_COLS  = 3'd3,
		REG_GA_EN = 3'd4,
		REG_GB_EN = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]      shape;
		logic [IdxW:0]   m;
		logic [IdxW:0]   k;
		logic [IdxW:0]   n;
		logic            ga_en;
		logic            gb_en;
	} cfg_t;

	function automatic logic [IdxW:0] clamp_dim(input logic [DimW-1:0] d);
		logic [IdxW:0] r;
		if (d == '0) begin
			r = (IdxW+1)'(1);
		end else if (32'(d) > MaxDim) begin
			r = (IdxW+1)'(MaxDim);
		end else begin
			r = (IdxW+1)'(d);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/mmbga_mac.sv -----
// Multiply stage: registered 32x32 product, floor-shifted, then accumulate.
// Depends on mmbga_pkg.
`default_nettype none
module mmbga_mac
	import mmbga_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     go,
	input  wire logic                     first,
	input  wire logic signed [31:0]       x,
	input  wire logic signed [31:0]       y,
	output logic                          done_s2,
	output logic signed [AccW-1:0]        acc_q
);
	logic signed [63:0] prod_s1;
	logic               go_s1, first_s1;
	logic signed [63:0] sh;

	assign sh = prod_s1 >>> FracBits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			go_s1 <= go;
			done_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(x) * 64'(y);
		first_s1 <= first;
		if (go_s1) begin
			acc_q <= first_s1 ? AccW'(sh) : acc_q + AccW'(sh);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/matmul_backward_grad_accumulate_unit.sv -----
// Top level of the matmul backward gradient accumulator.
// A load or unused-opcode beat has its result valid in the cycle after acceptance; a read passes
// through ST_RD to ST_OUT. A compute beat steps, per output, through ST_NEXT (setup), ST_TERM for each
// product term, ST_DRAIN until the multiplier is done, and the read-modify-write states ST_WB and
// ST_WB2; ST_NEXT skips a disabled pass. Clear zeroes one gradient entry per cycle over all entries
// and then returns its result; the same pass runs after reset. One beat is in flight at a time.
`default_nettype none
module matmul_backward_grad_accumulate_unit
	import mmbga_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // opcode[2:0], row[6:3], col[10:7], value[42:11]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // read_data[31:0], overflow_seen[32]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [4:0]  cfg_data
);
	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_RD, ST_OUT,
		ST_TERM, ST_DRAIN, ST_WB, ST_WB2, ST_NEXT
	} state_t;

	state_t state_q;
	cfg_t cfg_q;
	logic [31:0] mem_a [Cells], mem_b [Cells], mem_g [Cells], mem_ga [Cells], mem_gb [Cells];
	logic [AddrW-1:0] clr_q;
	logic ovf_q;
	logic [31:0] rd_q;
	logic [2:0] op_q;
	logic pass_q;
	logic [IdxW:0] i_q, j_q, t_q;
	logic [IdxW:0] n_i, n_j, n_t;
	logic [AddrW-1:0] ax, ay, wb_addr_q;
	logic [31:0] x_s, y_s, ga_rd, gb_rd;
	logic go, first, mac_done;
	logic signed [AccW-1:0] acc;
	logic signed [AccW:0] sum;
	logic signed [31:0] sat;
	logic sat_ovf;

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = {7'd0, ovf_q, rd_q};

	function automatic logic [AddrW-1:0] at(input logic [IdxW:0] r, input logic [IdxW:0] c);
		return {r[IdxW-1:0], c[IdxW-1:0]};
	endfunction

	// Loop limits per pass: pass 0 targets grad A, pass 1 grad B.
	always_comb begin
		n_i = (IdxW+1)'(1); n_j = (IdxW+1)'(1); n_t = (IdxW+1)'(1);
		ax = '0; ay = '0;
		unique case (cfg_q.shape)
			2'd0: begin
				if (!pass_q) begin
					n_i = cfg_q.k; n_j = (IdxW+1)'(1); n_t = cfg_q.n;
					ax = at(i_q, t_q); ay = at(t_q, '0);
				end else begin
					n_i = cfg_q.k; n_j = cfg_q.n; n_t = (IdxW+1)'(1);
					ax = at(j_q, '0); ay = at(i_q, '0);
				end
			end
			2'd1: begin
				if (!pass_q) begin
					n_i = cfg_q.m; n_j = cfg_q.k; n_t = (IdxW+1)'(1);
					ax = at(i_q, '0); ay = at(j_q, '0);
				end else begin
					n_i = cfg_q.k; n_j = (IdxW+1)'(1); n_t = cfg_q.m;
					ax = at(t_q, i_q); ay = at(t_q, '0);
				end
			end
			2'd2: begin
				if (!pass_q) begin
					n_i = cfg_q.m; n_j = cfg_q.k; n_t = cfg_q.n;
					ax = at(i_q, t_q); ay = at(j_q, t_q);
				end else begin
					n_i = cfg_q.k; n_j = cfg_q.n; n_t = cfg_q.m;
					ax = at(t_q, i_q); ay = at(t_q, j_q);
				end
			end
			default: begin
				n_i = cfg_q.k;
				ax = at(i_q, '0); ay = '0;
			end
		endcase
	end

	// Operand reads: x from A/B/G, y from G/B/A by mode and pass.
	always_ff @(posedge clk) begin
		logic [1:0] sh;
		sh = cfg_q.shape;
		if (sh == 2'd0) begin
			x_s <= pass_q ? mem_g[ax] : mem_b[ax];
			y_s <= pass_q ? mem_a[ay] : mem_g[ay];
		end else if (sh == 2'd1) begin
			x_s <= pass_q ? mem_a[ax] : mem_g[ax];
			y_s <= pass_q ? mem_g[ay] : mem_b[ay];
		end else if (sh == 2'd2) begin
			x_s <= pass_q ? mem_a[ax] : mem_g[ax];
			y_s <= pass_q ? mem_g[ay] : mem_b[ay];
		end else begin
			x_s <= pass_q ? mem_a[ax] : mem_b[ax];
			y_s <= mem_g[ay];
		end
	end

	mmbga_mac u_mac (
		.clk(clk), .arst_n(arst_n), .go(go), .first(first),
		.x(x_s), .y(y_s), .done_s2(mac_done), .acc_q(acc)
	);

	// go is registered alongside the operand read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go <= 1'b0;
			first <= 1'b0;
		end else begin
			go <= (state_q == ST_TERM);
			first <= (state_q == ST_TERM) && (t_q == '0);
		end
	end

	assign sum = (AccW+1)'($signed(pass_q ? gb_rd : ga_rd)) + (AccW+1)'(acc);
	always_comb begin
		sat_ovf = 1'b0;
		sat = sum[31:0];
		if (sum > (AccW+1)'(32'sh7fffffff)) begin
			sat = 32'sh7fffffff; sat_ovf = 1'b1;
		end else if (sum < -(AccW+1)'(33'sh080000000)) begin
			sat = 32'sh80000000; sat_ovf = 1'b1;
		end
	end

	// Gradient memories: one read port, one write port each.
	always_ff @(posedge clk) begin
		logic [AddrW-1:0] ra;
		ra = (state_q == ST_IDLE) ? {s_tdata[6:3], s_tdata[10:7]} : wb_addr_q;
		ga_rd <= mem_ga[ra];
		gb_rd <= mem_gb[ra];
		if (state_q == ST_CLR) begin
			mem_ga[clr_q] <= '0;
			mem_gb[clr_q] <= '0;
		end else if (state_q == ST_WB2) begin
			if (!pass_q) mem_ga[wb_addr_q] <= sat;
			else mem_gb[wb_addr_q] <= sat;
		end
		if (state_q == ST_IDLE && s_tvalid) begin
			unique case (opcode_t'(s_tdata[2:0]))
				OP_LOAD_A: mem_a[{s_tdata[6:3], s_tdata[10:7]}] <= s_tdata[42:11];
				OP_LOAD_B: mem_b[{s_tdata[6:3], s_tdata[10:7]}] <= s_tdata[42:11];
				OP_LOAD_G: mem_g[{s_tdata[6:3], s_tdata[10:7]}] <= s_tdata[42:11];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			ovf_q <= 1'b0;
			cfg_q <= '{shape: 2'd2, m: (IdxW+1)'(16), k: (IdxW+1)'(16), n: (IdxW+1)'(16),
				ga_en: 1'b1, gb_en: 1'b1};
			rd_q <= '0; op_q <= '0; pass_q <= 1'b0;
			i_q <= '0; j_q <= '0; t_q <= '0; wb_addr_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SHAPE: cfg_q.shape <= cfg_data[1:0];
					REG_ROWS:  cfg_q.m <= clamp_dim(cfg_data);
					REG_INNER: cfg_q.k <= clamp_dim(cfg_data);
					REG_COLS:  cfg_q.n <= clamp_dim(cfg_data);
					REG_GA_EN: cfg_q.ga_en <= cfg_data[0];
					REG_GB_EN: cfg_q.gb_en <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= (op_q == OP_CLEAR) ? ST_OUT : ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) begin
					op_q <= s_tdata[2:0];
					rd_q <= '0;
					unique case (opcode_t'(s_tdata[2:0]))
						OP_COMPUTE: begin
							pass_q <= 1'b0; i_q <= '0; j_q <= '0; t_q <= '0;
							state_q <= ST_NEXT;
						end
						OP_CLEAR: begin
							ovf_q <= 1'b0; clr_q <= '0; state_q <= ST_CLR;
						end
						OP_READ_GA, OP_READ_GB: state_q <= ST_RD;
						default: state_q <= ST_OUT;
					endcase
				end
				ST_RD: begin
					rd_q <= (op_q == OP_READ_GA) ? ga_rd : gb_rd;
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				ST_NEXT: begin
					// Skip a pass whose enable is clear, or finish.
					if ((!pass_q && !cfg_q.ga_en) || (pass_q && !cfg_q.gb_en)) begin
						if (pass_q) state_q <= ST_OUT;
						else begin pass_q <= 1'b1; i_q <= '0; j_q <= '0; t_q <= '0; end
					end else begin
						wb_addr_q <= (cfg_q.shape == 2'd0 || cfg_q.shape == 2'd3) &&
							!(cfg_q.shape == 2'd0 && pass_q) ? at(i_q, '0) :
							(cfg_q.shape == 2'd1 && pass_q) ? at(i_q, '0) : at(i_q, j_q);
						t_q <= '0;
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					if (t_q + 1'b1 >= n_t) state_q <= ST_DRAIN;
					else t_q <= t_q + 1'b1;
				end
				ST_DRAIN: if (mac_done && !go) state_q <= ST_WB;
				ST_WB: state_q <= ST_WB2;
				ST_WB2: begin
					if (sat_ovf) ovf_q <= 1'b1;
					state_q <= ST_NEXT;
					if (j_q + 1'b1 < n_j) j_q <= j_q + 1'b1;
					else begin
						j_q <= '0;
						if (i_q + 1'b1 < n_i) i_q <= i_q + 1'b1;
						else begin
							i_q <= '0;
							if (pass_q) state_q <= ST_OUT;
							else pass_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/mmbga_checker.sv -----
// Port checker for the gradient accumulator, bound to the top level.
// Does not import mmbga_pkg; it sees only the top level's ports.
`default_nettype none
module mmbga_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("two items in flight");
endmodule
bind matmul_backward_grad_accumulate_unit mmbga_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
